// ===== rtl/core/ljbf_pkg.sv =====
// ----------------------------------------------------------------------------
// ljbf_pkg
// Shared types, constants and command/status structs for the boundary force
// block.
// ----------------------------------------------------------------------------
package ljbf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_EN  = 2'd3;

    localparam logic [31:0] CUTOFF_RST   = 32'd65536;
    localparam logic [31:0] STRENGTH_RST = 32'd65536;
    localparam logic [31:0] GRAVITY_RST  = 32'd642908;
    localparam logic        GRAV_EN_RST  = 1'b1;

    // magnitude ceiling of the fixed-point products and quotients, 2^62
    localparam logic [62:0] MAG_CAP = 63'h4000_0000_0000_0000;

    localparam logic [31:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] OUT_MIN = 32'h8000_0000;

    typedef logic [3:0] step_t;

    localparam step_t STEP_SQX  = 4'd0;
    localparam step_t STEP_SQY  = 4'd1;
    localparam step_t STEP_R0SQ = 4'd2;
    localparam step_t STEP_SQRT = 4'd3;
    localparam step_t STEP_DIVQ = 4'd4;
    localparam step_t STEP_Q2   = 4'd5;
    localparam step_t STEP_Q4   = 4'd6;
    localparam step_t STEP_Q8   = 4'd7;
    localparam step_t STEP_Q12  = 4'd8;
    localparam step_t STEP_T    = 4'd9;
    localparam step_t STEP_DIVU = 4'd10;
    localparam step_t STEP_DIVF = 4'd11;
    localparam step_t STEP_MX   = 4'd12;
    localparam step_t STEP_MY   = 4'd13;

    typedef struct packed {
        logic  load;
        logic  go;
        step_t step;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic pair_active;
        logic last;
        logic in_range;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/ljbf_mulu.sv =====
// ----------------------------------------------------------------------------
// ljbf_mulu
// 64x64 unsigned multiplier built from one 32x32 multiplier, four partial
// products formed in turn and accumulated.
// ----------------------------------------------------------------------------
module ljbf_mulu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         go,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;

    logic [31:0]  part_a;
    logic [31:0]  part_b;
    logic [63:0]  pp_next;
    logic [1:0]   prev_sel;
    logic [127:0] pp_shifted;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin
                part_a = a_reg[31:0];
                part_b = b_reg[31:0];
            end
            2'd1: begin
                part_a = a_reg[31:0];
                part_b = b_reg[63:32];
            end
            2'd2: begin
                part_a = a_reg[63:32];
                part_b = b_reg[31:0];
            end
            default: begin
                part_a = a_reg[63:32];
                part_b = b_reg[63:32];
            end
        endcase
        pp_next  = 64'(part_a) * 64'(part_b);
        prev_sel = 2'(cnt_reg - 3'd1);
        case (prev_sel)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg <= pp_next;
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/ljbf_divu.sv =====
// ----------------------------------------------------------------------------
// ljbf_divu
// Restoring divider, one quotient bit per cycle: min(floor(a*2^F/b), 2^62).
// ----------------------------------------------------------------------------
module ljbf_divu #(
    parameter int FRAC_BITS = ljbf_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [63:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [62:0] quo
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   b_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          ge;
    logic          over;

    always_comb begin
        trial = {rem_reg, num_reg[NW-1]};
        diff  = trial - {1'b0, b_reg};
        ge    = trial >= {1'b0, b_reg};
        over  = (|quo_reg[NW-1:63]) || (quo_reg[62] && (|quo_reg[61:0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            num_reg <= {op_a, FRAC_BITS'(0)};
            quo_reg <= '0;
            rem_reg <= '0;
            b_reg   <= op_b;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[31:0] : trial[31:0];
        end
    end

    assign done = done_reg;
    assign quo  = over ? ljbf_pkg::MAG_CAP : quo_reg[62:0];

endmodule

// ===== rtl/core/ljbf_sqrtu.sv =====
// ----------------------------------------------------------------------------
// ljbf_sqrtu
// Digit-by-digit integer square root of a 64-bit value, one root bit per
// cycle.
// ----------------------------------------------------------------------------
module ljbf_sqrtu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [63:0] op_v,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [35:0] t_val;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb begin
        t_val = {rem_reg, v_reg[63:62]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = t_val - trial;
        ge    = t_val >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            v_reg    <= op_v;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            v_reg    <= {v_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[33:0] : t_val[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/ljbf_dpath.sv =====
// ----------------------------------------------------------------------------
// ljbf_dpath
// Datapath: configuration registers, item registers, operand selection for
// the shared multiplier, divider and square root, accumulators and the
// output register.
// ----------------------------------------------------------------------------
module ljbf_dpath #(
    parameter int FRAC_BITS = ljbf_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ljbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ljbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [127:0]                    s_tdata,
    input  logic [3:0]                      s_tuser,
    input  logic                            s_tlast,
    input  ljbf_pkg::cmd_t                  cmd,
    output ljbf_pkg::status_t               status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [63:0]                     m_tdata,
    output logic [0:0]                      m_tuser
);

    localparam logic [31:0] OUT_MIN_U = ljbf_pkg::OUT_MIN;

    logic [31:0] cutoff_reg;
    logic [31:0] strength_reg;
    logic [31:0] gravity_reg;
    logic        grav_en_reg;

    logic        pair_reg;
    logic        last_reg;
    logic [31:0] ax_reg;
    logic [31:0] ay_reg;
    logic        xneg_reg;
    logic        yneg_reg;
    logic [63:0] sx_reg;
    logic [63:0] sy_reg;
    logic [63:0] r0sq_reg;
    logic [31:0] r_reg;
    logic [62:0] w_reg;
    logic [62:0] q4_reg;

    logic [31:0] sum_x_reg;
    logic [31:0] sum_y_reg;
    logic        clip_reg;

    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_sat_reg;

    logic [32:0]  dx;
    logic [32:0]  dy;
    logic [32:0]  dx_mag;
    logic [32:0]  dy_mag;
    logic [64:0]  r2_full;

    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic [63:0]  div_a;
    logic         is_mul;
    logic         is_div;
    logic         is_sqrt;
    logic [62:0]  diff_q;

    logic         mul_done;
    logic [127:0] mul_prod;
    logic [127:0] prod_shr;
    logic [62:0]  mul_fx;
    logic         div_done;
    logic [62:0]  div_quo;
    logic         sqrt_done;
    logic [31:0]  sqrt_root;

    logic [63:0]  acc_in;
    logic [63:0]  acc_add;
    logic [63:0]  acc_sum;
    logic         acc_over;
    logic [31:0]  acc_clip;

    logic [32:0]  neg_g;
    logic         g_over;

    always_comb begin
        dx     = {s_tdata[31], s_tdata[31:0]} - {s_tdata[95], s_tdata[95:64]};
        dy     = {s_tdata[63], s_tdata[63:32]} - {s_tdata[127], s_tdata[127:96]};
        dx_mag = dx[32] ? (~dx + 33'd1) : dx;
        dy_mag = dy[32] ? (~dy + 33'd1) : dy;
        neg_g  = ~{1'b0, gravity_reg} + 33'd1;
        g_over = gravity_reg > OUT_MIN_U;
    end

    always_comb begin
        r2_full = {1'b0, sx_reg} + {1'b0, sy_reg};
        diff_q  = (w_reg > q4_reg) ? (w_reg - q4_reg) : '0;
        is_mul  = 1'b0;
        is_div  = 1'b0;
        is_sqrt = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_a   = '0;
        case (cmd.step)
            ljbf_pkg::STEP_SQX: begin
                is_mul = 1'b1;
                mul_a  = 64'(ax_reg);
                mul_b  = 64'(ax_reg);
            end
            ljbf_pkg::STEP_SQY: begin
                is_mul = 1'b1;
                mul_a  = 64'(ay_reg);
                mul_b  = 64'(ay_reg);
            end
            ljbf_pkg::STEP_R0SQ: begin
                is_mul = 1'b1;
                mul_a  = 64'(cutoff_reg);
                mul_b  = 64'(cutoff_reg);
            end
            ljbf_pkg::STEP_SQRT: begin
                is_sqrt = 1'b1;
            end
            ljbf_pkg::STEP_DIVQ: begin
                is_div = 1'b1;
                div_a  = 64'(cutoff_reg);
            end
            ljbf_pkg::STEP_Q2, ljbf_pkg::STEP_Q4, ljbf_pkg::STEP_Q8: begin
                is_mul = 1'b1;
                mul_a  = 64'(w_reg);
                mul_b  = 64'(w_reg);
            end
            ljbf_pkg::STEP_Q12: begin
                is_mul = 1'b1;
                mul_a  = 64'(w_reg);
                mul_b  = 64'(q4_reg);
            end
            ljbf_pkg::STEP_T: begin
                is_mul = 1'b1;
                mul_a  = 64'(strength_reg);
                mul_b  = 64'(diff_q);
            end
            ljbf_pkg::STEP_DIVU, ljbf_pkg::STEP_DIVF: begin
                is_div = 1'b1;
                div_a  = 64'(w_reg);
            end
            ljbf_pkg::STEP_MX: begin
                is_mul = 1'b1;
                mul_a  = 64'(ax_reg);
                mul_b  = 64'(w_reg);
            end
            ljbf_pkg::STEP_MY: begin
                is_mul = 1'b1;
                mul_a  = 64'(ay_reg);
                mul_b  = 64'(w_reg);
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
    end

    ljbf_mulu u_mulu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (cmd.go && is_mul),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ljbf_divu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (cmd.go && is_div),
        .op_a    (div_a),
        .op_b    (r_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    ljbf_sqrtu u_sqrtu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (cmd.go && is_sqrt),
        .op_v    (r2_full[63:0]),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_comb begin
        prod_shr = mul_prod >> FRAC_BITS;
        mul_fx   = ((|prod_shr[127:63]) || (prod_shr[62] && (|prod_shr[61:0])))
                   ? ljbf_pkg::MAG_CAP : prod_shr[62:0];
        acc_in   = (cmd.step == ljbf_pkg::STEP_MX)
                   ? {{32{sum_x_reg[31]}}, sum_x_reg} : {{32{sum_y_reg[31]}}, sum_y_reg};
        if ((cmd.step == ljbf_pkg::STEP_MX) ? xneg_reg : yneg_reg) begin
            acc_add = ~{1'b0, mul_fx} + 64'd1;
        end else begin
            acc_add = {1'b0, mul_fx};
        end
        acc_sum  = acc_in + acc_add;
        acc_over = !((&acc_sum[63:31]) || !(|acc_sum[63:31]));
        if (acc_over) begin
            acc_clip = acc_sum[63] ? ljbf_pkg::OUT_MIN : ljbf_pkg::OUT_MAX;
        end else begin
            acc_clip = acc_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= ljbf_pkg::CUTOFF_RST;
            strength_reg <= ljbf_pkg::STRENGTH_RST;
            gravity_reg  <= ljbf_pkg::GRAVITY_RST;
            grav_en_reg  <= ljbf_pkg::GRAV_EN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ljbf_pkg::REG_CUTOFF:   cutoff_reg   <= cfg_wdata;
                ljbf_pkg::REG_STRENGTH: strength_reg <= cfg_wdata;
                ljbf_pkg::REG_GRAVITY:  gravity_reg  <= cfg_wdata;
                ljbf_pkg::REG_GRAV_EN:  grav_en_reg  <= cfg_wdata[0];
                default:                grav_en_reg  <= grav_en_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg  <= 1'b0;
            last_reg  <= 1'b0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            clip_reg  <= 1'b0;
        end else if (cmd.load) begin
            pair_reg <= s_tuser[0] && s_tuser[1] && s_tuser[2];
            last_reg <= s_tlast;
            if (s_tuser[3]) begin
                sum_x_reg <= '0;
                if (!grav_en_reg) begin
                    sum_y_reg <= '0;
                    clip_reg  <= 1'b0;
                end else if (g_over) begin
                    sum_y_reg <= ljbf_pkg::OUT_MIN;
                    clip_reg  <= 1'b1;
                end else begin
                    sum_y_reg <= neg_g[31:0];
                    clip_reg  <= 1'b0;
                end
            end
        end else if (mul_done && (cmd.step == ljbf_pkg::STEP_MX)) begin
            sum_x_reg <= acc_clip;
            clip_reg  <= clip_reg || acc_over;
        end else if (mul_done && (cmd.step == ljbf_pkg::STEP_MY)) begin
            sum_y_reg <= acc_clip;
            clip_reg  <= clip_reg || acc_over;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg   <= dx_mag[31:0];
            ay_reg   <= dy_mag[31:0];
            xneg_reg <= dx[32];
            yneg_reg <= dy[32];
        end
        if (mul_done) begin
            case (cmd.step)
                ljbf_pkg::STEP_SQX:  sx_reg   <= mul_prod[63:0];
                ljbf_pkg::STEP_SQY:  sy_reg   <= mul_prod[63:0];
                ljbf_pkg::STEP_R0SQ: r0sq_reg <= mul_prod[63:0];
                ljbf_pkg::STEP_Q4: begin
                    w_reg  <= mul_fx;
                    q4_reg <= mul_fx;
                end
                ljbf_pkg::STEP_Q2, ljbf_pkg::STEP_Q8, ljbf_pkg::STEP_Q12,
                ljbf_pkg::STEP_T:    w_reg    <= mul_fx;
                default:             w_reg    <= w_reg;
            endcase
        end
        if (div_done) begin
            w_reg <= div_quo;
        end
        if (sqrt_done) begin
            r_reg <= sqrt_root;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {sum_y_reg, sum_x_reg};
            m_sat_reg  <= clip_reg;
        end
    end

    always_comb begin
        status.pair_active = pair_reg;
        status.last        = last_reg;
        status.in_range    = (r2_full != 65'd0) && (r2_full < {1'b0, r0sq_reg});
        status.mul_done    = mul_done;
        status.div_done    = div_done;
        status.sqrt_done   = sqrt_done;
        status.out_free    = !m_valid_reg || m_tready;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule

// ===== rtl/core/ljbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ljbf_ctrl
// Controller: takes one item, walks the datapath through the force steps for an
// active pair and, on a list's last item, hands the result to the output register.
// ----------------------------------------------------------------------------
module ljbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ljbf_pkg::status_t status,
    output ljbf_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    ljbf_pkg::step_t step_reg;
    ljbf_pkg::step_t step_next;
    logic            unit_done;
    logic [2:0]      finish_state;

    always_comb begin
        unit_done    = status.mul_done || status.div_done || status.sqrt_done;
        finish_state = status.last ? S_EMIT : S_IDLE;
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.load     = 1'b0;
        cmd.go       = 1'b0;
        cmd.step     = step_reg;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (status.pair_active) begin
                    step_next  = ljbf_pkg::STEP_SQX;
                    state_next = S_ISSUE;
                end else begin
                    state_next = finish_state;
                end
            end
            S_ISSUE: begin
                cmd.go     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (unit_done) begin
                    if (step_reg == ljbf_pkg::STEP_R0SQ) begin
                        state_next = S_CHECK;
                    end else if (step_reg == ljbf_pkg::STEP_MY) begin
                        state_next = finish_state;
                    end else begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_CHECK: begin
                if (status.in_range) begin
                    step_next  = ljbf_pkg::STEP_SQRT;
                    state_next = S_ISSUE;
                end else begin
                    state_next = finish_state;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= ljbf_pkg::STEP_SQX;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== rtl/core/lennard_jones_boundary_force.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_boundary_force
// 12-4 boundary repulsion accumulator over a particle's neighbour list,
// Q16.16 fixed point, one acceleration per list.
//
//   channel   dir  payload
//   s_*       in   tdata: self_x, self_y, neighbour_x, neighbour_y
//                  tuser: self_is_material, neighbour_is_virtual,
//                         neighbour_present, first_neighbour; tlast: last
//   m_*       out  tdata: accel_x, accel_y; tuser: saturated
//   cfg_*     in   cutoff_radius, force_strength, gravity_value, gravity_enable
//
// An item without an active pair is only loaded; an out-of-range pair also runs
// the three squaring steps, an in-range pair the whole step chain, in which the
// bit-serial divider runs three times. A list's last item adds an emit step.
// Reset is synchronous; nothing to clear afterwards.
// A pending result in the output register does not stop the next item; only
// the emit of a later list waits for it to be taken.
// ----------------------------------------------------------------------------
module lennard_jones_boundary_force #(
    parameter int FRAC_BITS = ljbf_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ljbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ljbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // self_x, self_y, neighbour_x, neighbour_y
    input  logic [127:0]                    s_tdata,
    // self_is_material, neighbour_is_virtual, neighbour_present, first_neighbour
    input  logic [3:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accel_x, accel_y
    output logic [63:0]                     m_tdata,
    // saturated
    output logic [0:0]                      m_tuser
);

    ljbf_pkg::cmd_t    cmd;
    ljbf_pkg::status_t status;

    ljbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ljbf_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result emitted over an untaken result");

    a_one_unit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({status.mul_done, status.div_done, status.sqrt_done}))
        else $error("two arithmetic units finished together");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !(status.mul_done || status.div_done || status.sqrt_done))
        else $error("item taken while a unit was finishing");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ===== bench/lennard_jones_boundary_force_tb.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_boundary_force_tb
// Drives neighbour-list transfers into the boundary force block and checks each
// emitted acceleration against an in-bench fixed-point force predictor, across
// several register settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module lennard_jones_boundary_force_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LO32 = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        sat;
    } accel_t;

    typedef struct {
        logic [31:0] sx, sy, nx, ny;
        logic mat, virt, pres, first, last;
    } pair_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [ljbf_pkg::CFG_IDX_W-1:0] cfg_index = ljbf_pkg::REG_CUTOFF;
    logic [ljbf_pkg::CFG_DATA_W-1:0] cfg_wdata = 0;
    logic s_tvalid = 0, s_tready, s_tlast = 0;
    logic [127:0] s_tdata = 0;
    logic [3:0] s_tuser = 0;
    logic m_tvalid, m_tready = 0;
    logic [63:0] m_tdata;
    logic [0:0] m_tuser;

    lennard_jones_boundary_force DUT (.*);

    initial forever #2 aclk = ~aclk;

    // predictor state
    logic [31:0] r0_reg = ljbf_pkg::CUTOFF_RST;
    logic [31:0] d_reg = ljbf_pkg::STRENGTH_RST;
    logic [31:0] g_reg = ljbf_pkg::GRAVITY_RST;
    logic ge_reg = ljbf_pkg::GRAV_EN_RST;
    longint acc_x = 0, acc_y = 0;
    logic clipped = 0;
    accel_t accel_q[$];
    int errors = 0;
    int hold_off = 0;
    int burst_left = 0;

    function automatic logic [63:0] fxmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [127:0] v;
        p = a * b;
        v = p >> FB;
        return (v > CAP) ? CAP : v[63:0];
    endfunction

    function automatic logic [63:0] fxdiv(logic [63:0] a, logic [63:0] b);
        logic [127:0] v;
        v = ({64'd0, a} << FB) / b;
        return (v > CAP) ? CAP : v[63:0];
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if (128'((r | (64'd1 << b))) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
        return r;
    endfunction

    function automatic longint clip_acc(longint v);
        if (v > 64'sh7FFF_FFFF) begin
            clipped = 1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            clipped = 1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic longint part(longint d, logic [63:0] f);
        logic [63:0] m;
        m = fxmul(d < 0 ? -d : d, f);
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    task automatic add_force(longint dx, longint dy);
        logic [63:0] ax, ay, r0, r2, r, q, q2, q4, q12, df, t, f;
        logic [64:0] s;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        r0 = r0_reg;
        if (ax > LO32 || ay > LO32) return;
        s = 65'(ax * ax) + 65'(ay * ay);
        if (s[64]) return;
        r2 = s[63:0];
        if (r2 == 0 || r2 >= r0 * r0) return;
        r = isqrt(r2);
        q = (r0 << FB) / r;
        q2 = fxmul(q, q);
        q4 = fxmul(q2, q2);
        q12 = fxmul(fxmul(q4, q4), q4);
        df = q12 > q4 ? q12 - q4 : 0;
        t = fxmul(d_reg, df);
        f = fxdiv(fxdiv(t, r), r);
        acc_x = clip_acc(acc_x + part(dx, f));
        acc_y = clip_acc(acc_y + part(dy, f));
    endtask

    task automatic predict_accel(pair_t p);
        accel_t e;
        if (p.first) begin
            clipped = 0;
            acc_x = 0;
            acc_y = ge_reg ? clip_acc(-longint'(g_reg)) : 0;
        end
        if (p.pres && p.mat && p.virt)
            add_force(longint'(signed'(p.sx)) - longint'(signed'(p.nx)),
                      longint'(signed'(p.sy)) - longint'(signed'(p.ny)));
        if (p.last) begin
            e.ax = acc_x[31:0];
            e.ay = acc_y[31:0];
            e.sat = clipped;
            accel_q.push_back(e);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        accel_t e;
        if (m_tvalid && m_tready) begin
            if (accel_q.size() == 0) begin
                report("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                e = accel_q.pop_front();
                if (m_tdata[31:0] !== e.ax) report("accel_x", m_tdata[31:0], e.ax);
                if (m_tdata[63:32] !== e.ay) report("accel_y", m_tdata[63:32], e.ay);
                if (m_tuser[0] !== e.sat)
                    report("saturated", 32'(m_tuser[0]), 32'(e.sat));
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_pair(pair_t p);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= {p.ny, p.nx, p.sy, p.sx};
        s_tuser <= {p.first, p.pres, p.virt, p.mat};
        s_tlast <= p.last;
        do @(posedge aclk); while (!s_tready);
        predict_accel(p);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (accel_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ljbf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            ljbf_pkg::REG_CUTOFF:   r0_reg = val;
            ljbf_pkg::REG_STRENGTH: d_reg = val;
            ljbf_pkg::REG_GRAVITY:  g_reg = val;
            default:                ge_reg = val[0];
        endcase
        @(posedge aclk);
    endtask

    function automatic pair_t near_pair(logic [31:0] span);
        pair_t p;
        p.sx = $urandom;
        p.sy = $urandom;
        p.nx = p.sx - (span == 0 ? 0 : $urandom_range(0, span) - span / 2);
        p.ny = p.sy - (span == 0 ? 0 : $urandom_range(0, span) - span / 2);
        p.mat = 1;
        p.virt = 1;
        p.pres = 1;
        p.first = 0;
        p.last = 0;
        return p;
    endfunction

    task automatic test_directed();
        pair_t p;
        // in range, out of range, zero distance, wrong types, framing only
        p = near_pair(0);
        p.nx = p.sx - 32'h0000_8000;
        p.first = 1;
        send_pair(p);
        p.nx = p.sx + 32'h0002_0000;
        send_pair(p);
        p.nx = p.sx;
        send_pair(p);
        p = near_pair(32'h8000);
        p.mat = 0;
        send_pair(p);
        p = near_pair(32'h8000);
        p.virt = 0;
        send_pair(p);
        p = near_pair(32'h8000);
        p.pres = 0;
        p.last = 1;
        send_pair(p);
        // no first mark: continues on old sums; then both marks on one item
        p = near_pair(32'h4000);
        p.last = 1;
        send_pair(p);
        p = near_pair(32'h4000);
        p.first = 1;
        p.last = 1;
        send_pair(p);
        // extreme coordinates
        p = near_pair(0);
        p.sx = 32'h7FFF_FFFF;
        p.nx = 32'h8000_0000;
        p.sy = 32'h8000_0000;
        p.ny = 32'h7FFF_FFFF;
        p.first = 1;
        p.last = 1;
        send_pair(p);
        p = near_pair(0);
        p.nx = p.sx + 1;
        p.first = 1;
        p.last = 1;
        send_pair(p);
        drain();
    endtask

    task automatic test_lists(int n, logic [31:0] span);
        pair_t p;
        int len, k;
        k = 0;
        while (k < n) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                p = near_pair(span);
                if ($urandom_range(0, 9) == 0) p.mat = 0;
                if ($urandom_range(0, 9) == 0) p.virt = 0;
                if ($urandom_range(0, 15) == 0) p.pres = 0;
                if ($urandom_range(0, 7) == 0) begin
                    p.sx = $urandom;
                    p.nx = $urandom;
                end
                p.first = (i == 0) ^ ($urandom_range(0, 30) == 0);
                p.last = (i == len - 1) ^ ($urandom_range(0, 30) == 0);
                send_pair(p);
                k++;
            end
        end
    endtask

    task automatic test_backpressure();
        pair_t p;
        hold_off = 3000;
        for (int i = 0; i < 12; i++) begin
            p = near_pair(32'h1000);
            p.first = 1;
            p.last = 1;
            send_pair(p);
        end
        drain();
    endtask

    initial begin : timeout
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_lists(500, 32'h0001_0000);
        drain();
        write_reg(ljbf_pkg::REG_CUTOFF, 32'h0004_0000);
        write_reg(ljbf_pkg::REG_STRENGTH, 32'hFFFF_FFFF);
        write_reg(ljbf_pkg::REG_GRAVITY, 32'hFFFF_FFFF);
        write_reg(ljbf_pkg::REG_GRAV_EN, 1);
        test_lists(450, 32'h0006_0000);
        test_backpressure();
        write_reg(ljbf_pkg::REG_CUTOFF, 32'h0);
        write_reg(ljbf_pkg::REG_STRENGTH, 32'h0);
        write_reg(ljbf_pkg::REG_GRAVITY, 32'h0);
        write_reg(ljbf_pkg::REG_GRAV_EN, 0);
        test_lists(200, 32'h0001_0000);
        drain();
        write_reg(ljbf_pkg::REG_CUTOFF, 32'hFFFF_FFFF);
        write_reg(ljbf_pkg::REG_STRENGTH, 32'h0000_0100);
        write_reg(ljbf_pkg::REG_GRAVITY, 32'h0009_CF5C);
        write_reg(ljbf_pkg::REG_GRAV_EN, 1);
        test_lists(400, 32'hFFFF_FFFF);
        drain();
        write_reg(ljbf_pkg::REG_CUTOFF, 32'h0000_8000);
        write_reg(ljbf_pkg::REG_STRENGTH, 32'h0050_0000);
        test_lists(400, 32'h0000_C000);
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ljbf_pkg.sv
rtl/core/ljbf_mulu.sv
rtl/core/ljbf_divu.sv
rtl/core/ljbf_sqrtu.sv
rtl/core/ljbf_dpath.sv
rtl/core/ljbf_ctrl.sv
rtl/core/lennard_jones_boundary_force.sv
bench/lennard_jones_boundary_force_tb.sv
